/* rtl/core/lvg_pkg.sv */
// lvg_pkg: shared types, codes and constants of the vibrato lfo core
// standalone, no dependencies; imported by every lvg module
`default_nettype none

package lvg_pkg;

    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    typedef enum logic [1:0] {
        REG_PHASE_INC = 2'd0,
        REG_WAVEFORM  = 2'd1,
        REG_DEPTH     = 2'd2,
        REG_INTERVAL  = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_SAW      = 2'd2,
        WAVE_SQUARE   = 2'd3
    } wave_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAVE,
        ST_MUL_DEPTH,
        ST_MUL_RECIP,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_DEPTH,
        MUL_RECIP
    } mul_op_t;

    typedef struct packed {
        logic    accept;
        logic    wave_en;
        mul_op_t mul_op;
        logic    out_load;
    } ctrl_t;

    localparam logic signed [15:0] Q14_ONE       = 16'sd16384;
    localparam logic signed [15:0] Q14_MINUS_ONE = -16'sd16384;
    localparam logic [16:0]        FACTOR_ONE    = 17'd65536;
    localparam logic [11:0]        INTERVAL_RST  = 12'd32;
    // (m + 640) / 1280 == ((m + 640) >> 8) / 5, and x / 5 == (x * 52429) >> 18 for x < 2^18
    localparam logic [24:0]        ROUND_HALF    = 25'd640;
    localparam logic [16:0]        RECIP_FIVE    = 17'd52429;
    localparam logic [63:0]        HALF_PI_Q30   = 64'd1686629713;

    // quarter-wave sine entry k, Taylor series in Q30, used at elaboration only
    function automatic logic [14:0] sine_entry(input int k, input int table_bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        x    = (64'(k) * HALF_PI_Q30) >> table_bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int n = 1; n <= 7; n++)
        begin
            term = (term * x2) >> 30;
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                default: term = term / 64'd210;
            endcase
            if (n % 2 == 1)
            begin
                sum = sum - signed'(term);
            end
            else
            begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0)
        begin
            sum = '0;
        end
        r = (unsigned'(sum) + 64'd32768) >> 16;
        if (r > 64'd16384)
        begin
            r = 64'd16384;
        end
        return r[14:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/lfo_vibrato_generator_core.sv */
// lfo_vibrato_generator_core: per-sample lfo with vibrato factor output
// an input transfer is followed by the rom read, the wave step, the two multiply passes and the output load
// one item at a time: no new input is taken until the shared multiplier and the output load are through with the last
// a stalled output holds the sequencer in its output state, and no input is taken while it waits
// reset (rst_n low, async): phase to mid-cycle, countdown and held value to zero,
// registers to increment 0, sine, depth 0, interval 32
`default_nettype none

module lfo_vibrato_generator_core
    import lvg_pkg::*;
#(
    parameter int PHASE_BITS      = 16,
    parameter int SINE_TABLE_BITS = 8
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // s_tdata: [0] sample_tick, [1] restart, [7:2] zero
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [7:0]                s_tdata,
    // m_tdata: [15:0] lfo_value, [32:16] vibrato_factor, [33] updated, [39:34] zero
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic      [39:0]               m_tdata,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int TB    = SINE_TABLE_BITS;
    localparam int ROM_N = 2 ** TB;
    localparam logic [PHASE_BITS-1:0] PHASE_HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};

    ctrl_t ctrl;

    // configuration
    logic [15:0] phase_inc_reg;
    wave_t       wave_sel_reg;
    logic [9:0]  depth_reg;
    logic [11:0] interval_reg;

    // oscillator state
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [11:0]           countdown_reg;
    logic [11:0]           countdown_next;
    logic signed [15:0]    held_reg;
    logic                  upd_reg;

    // output register
    logic                  m_tvalid_reg;
    logic [15:0]           out_lfo_reg;
    logic [16:0]           out_factor_reg;
    logic                  out_upd_reg;

    logic                  tick;
    logic                  restart;
    logic [11:0]           cd_base;
    logic [PHASE_BITS-1:0] phase_base;
    logic                  tick_upd;
    logic [PHASE_BITS+15:0] phase_sum;

    logic [PHASE_BITS-1:0] rom_q;
    logic [PHASE_BITS-3+TB:0] rom_ext;
    logic [TB-1:0]         rom_idx;
    logic [TB:0]           rom_addr;
    logic [14:0]           rom_data;

    logic [PHASE_BITS-1:0] tri_dist;
    logic [PHASE_BITS+15:0] tri_ext;
    logic [15:0]           tri_mag;
    logic [PHASE_BITS+14:0] saw_ext;
    logic [14:0]           saw_mag;
    logic signed [15:0]    wave_val;

    logic [14:0]           held_mag;
    logic [13:0]           adj;
    logic [16:0]           factor;

    assign tick    = s_tdata[0];
    assign restart = s_tdata[1];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_inc_reg <= '0;
            wave_sel_reg  <= WAVE_SINE;
            depth_reg     <= '0;
            interval_reg  <= INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_addr))
                REG_PHASE_INC: phase_inc_reg <= cfg_data;
                REG_WAVEFORM:  wave_sel_reg  <= wave_t'(cfg_data[1:0]);
                REG_DEPTH:     depth_reg     <= cfg_data[9:0];
                REG_INTERVAL:  interval_reg  <= cfg_data[11:0];
                default:       depth_reg     <= depth_reg;
            endcase
        end
    end

    // restart clears first, then the tick is applied
    always_comb
    begin
        cd_base    = restart ? 12'd0 : countdown_reg;
        phase_base = restart ? PHASE_HALF : phase_reg;
        tick_upd   = tick && (cd_base <= 12'd1);
        phase_sum  = {16'd0, phase_base} + {{PHASE_BITS{1'b0}}, phase_inc_reg};
        phase_next = tick_upd ? phase_sum[PHASE_BITS-1:0] : phase_base;
        if (!tick)
        begin
            countdown_next = cd_base;
        end
        else if (tick_upd)
        begin
            countdown_next = interval_reg;
        end
        else
        begin
            countdown_next = cd_base - 12'd1;
        end
    end

    // rom address from the new phase: quadrant and truncated index
    always_comb
    begin
        rom_q    = phase_next ^ PHASE_HALF;
        rom_ext  = {rom_q[PHASE_BITS-3:0], {TB{1'b0}}};
        rom_idx  = rom_ext[PHASE_BITS-2 +: TB];
        rom_addr = rom_q[PHASE_BITS-2] ? ((TB+1)'(ROM_N) - {1'b0, rom_idx}) : {1'b0, rom_idx};
    end

    lvg_sine_rom #(
        .TABLE_BITS (TB)
    ) u_rom (
        .clk  (clk),
        .en   (ctrl.accept),
        .addr (rom_addr),
        .data (rom_data)
    );

    // waveform from the stored phase
    always_comb
    begin
        tri_dist = phase_reg[PHASE_BITS-1] ? (phase_reg - PHASE_HALF) : (PHASE_HALF - phase_reg);
        tri_ext  = {tri_dist, 16'd0};
        tri_mag  = tri_ext[PHASE_BITS +: 16];
        saw_ext  = {phase_reg, 15'd0};
        saw_mag  = saw_ext[PHASE_BITS +: 15];
        case (wave_sel_reg)
            WAVE_SINE:
            begin
                if (phase_reg[PHASE_BITS-1])
                begin
                    wave_val = signed'({1'b0, rom_data});
                end
                else
                begin
                    wave_val = signed'(16'd0 - {1'b0, rom_data});
                end
            end
            WAVE_TRIANGLE: wave_val = signed'(16'd16384 - tri_mag);
            WAVE_SAW:      wave_val = signed'({1'b0, saw_mag} - 16'd16384);
            WAVE_SQUARE:
            begin
                if (phase_reg[PHASE_BITS-1] || (phase_reg == '0))
                begin
                    wave_val = Q14_ONE;
                end
                else
                begin
                    wave_val = Q14_MINUS_ONE;
                end
            end
            default:       wave_val = Q14_ONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PHASE_HALF;
            countdown_reg <= '0;
            held_reg      <= '0;
        end
        else if (ctrl.accept)
        begin
            phase_reg     <= phase_next;
            countdown_reg <= countdown_next;
            if (restart)
            begin
                held_reg <= '0;
            end
        end
        else if (ctrl.wave_en && upd_reg)
        begin
            held_reg <= wave_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            upd_reg <= tick_upd;
        end
    end

    assign held_mag = held_reg[15] ? 15'(16'd0 - unsigned'(held_reg)) : held_reg[14:0];

    lvg_mul_unit u_mul (
        .clk      (clk),
        .mul_op   (ctrl.mul_op),
        .held_mag (held_mag),
        .depth    (depth_reg),
        .adj      (adj)
    );

    assign factor = held_reg[15] ? (FACTOR_ONE - {3'd0, adj}) : (FACTOR_ONE + {3'd0, adj});

    lvg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .out_valid (m_tvalid_reg),
        .out_ready (m_tready),
        .in_ready  (s_tready),
        .ctrl      (ctrl)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_lfo_reg    <= unsigned'(held_reg);
            out_factor_reg <= factor;
            out_upd_reg    <= upd_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_upd_reg, out_factor_reg, out_lfo_reg};

`ifndef SYNTHESIS
    // one item at a time through the sequencer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in progress");

    a_wave_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> ctrl.wave_en)
        else $error("wave step did not follow the transfer");

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg <= Q14_ONE) && (held_reg >= Q14_MINUS_ONE))
        else $error("held value out of q1.14 range");

    a_zero_factor: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[15:0] == 16'd0)) |-> (m_tdata[32:16] == FACTOR_ONE))
        else $error("zero value with a factor other than one");
`endif

endmodule

`default_nettype wire

/* rtl/core/lvg_sine_rom.sv */
// lvg_sine_rom: quarter-wave sine table with registered read
// depends on lvg_pkg (sine_entry builds the constants at elaboration)
`default_nettype none

module lvg_sine_rom
    import lvg_pkg::*;
#(
    parameter int TABLE_BITS = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [TABLE_BITS:0]   addr,
    output logic      [14:0]           data
);

    localparam int ROM_N     = 2 ** TABLE_BITS;
    localparam int ADDR_SPAN = 2 ** (TABLE_BITS + 1);

    logic [14:0] table_w [ADDR_SPAN];
    logic [14:0] data_reg;

    for (genvar k = 0; k < ADDR_SPAN; k++)
    begin : g_entry
        if (k <= ROM_N)
        begin : g_used
            assign table_w[k] = sine_entry(k, TABLE_BITS);
        end
        else
        begin : g_pad
            assign table_w[k] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= table_w[addr];
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* rtl/core/lvg_mul_unit.sv */
// lvg_mul_unit: shared 17x17 multiplier with product register
// two passes give the rounded vibrato offset |value|*depth/1280; depends on lvg_pkg
`default_nettype none

module lvg_mul_unit
    import lvg_pkg::*;
(
    input  wire logic          clk,
    input  wire mul_op_t       mul_op,
    input  wire logic [14:0]   held_mag,
    input  wire logic [9:0]    depth,
    output logic      [13:0]   adj
);

    logic [16:0] op_a;
    logic [16:0] op_b;
    logic [33:0] prod_full;
    logic [24:0] rnd_sum;
    logic [31:0] prod_reg;

    // first pass product is below 2^25
    assign rnd_sum = prod_reg[24:0] + ROUND_HALF;

    always_comb
    begin
        case (mul_op)
            MUL_DEPTH:
            begin
                op_a = {2'b00, held_mag};
                op_b = {7'd0, depth};
            end
            MUL_RECIP:
            begin
                op_a = rnd_sum[24:8];
                op_b = RECIP_FIVE;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_full = op_a * op_b;

    always_ff @(posedge clk)
    begin
        if (mul_op != MUL_NONE)
        begin
            prod_reg <= prod_full[31:0];
        end
    end

    assign adj = prod_reg[31:18];

endmodule

`default_nettype wire

/* rtl/core/lvg_ctrl.sv */
// lvg_ctrl: sequencer stepping one item through wave, two multiply passes and output
// depends on lvg_pkg (state_t, ctrl_t)
`default_nettype none

module lvg_ctrl
    import lvg_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    input  wire logic   out_valid,
    input  wire logic   out_ready,
    output logic        in_ready,
    output ctrl_t       ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_WAVE;
                end
            end
            ST_WAVE:      state_next = ST_MUL_DEPTH;
            ST_MUL_DEPTH: state_next = ST_MUL_RECIP;
            ST_MUL_RECIP: state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_valid || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        ctrl.accept   = 1'b0;
        ctrl.wave_en  = 1'b0;
        ctrl.mul_op   = MUL_NONE;
        ctrl.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctrl.accept = in_valid;
            end
            ST_WAVE:      ctrl.wave_en = 1'b1;
            ST_MUL_DEPTH: ctrl.mul_op  = MUL_DEPTH;
            ST_MUL_RECIP: ctrl.mul_op  = MUL_RECIP;
            ST_OUT:       ctrl.out_load = !out_valid || out_ready;
            default:      ctrl.out_load = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

/* verif/tb_lfo_vibrato_generator_core.sv */
`timescale 1ns / 1ps
// tb_lfo_vibrato_generator_core: self-checking bench for the vibrato lfo core
// drives sample ticks over the stream input, predicts every output transfer in-bench
// depends on lvg_pkg and lfo_vibrato_generator_core only

module tb_lfo_vibrato_generator_core;
    import lvg_pkg::*;

    localparam int ROM_BITS    = 8;
    localparam int ROM_LAST    = 1 << ROM_BITS;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int SEG_ITEMS   = 72;

    typedef struct packed {
        logic signed [15:0] value;
        logic [16:0]        factor;
        logic               updated;
    } lfo_out_t;

    typedef struct {
        logic       is_write;
        reg_index_t addr;
        logic [15:0] data;
        logic       tick;
        logic       clr;
        logic       known;
        lfo_out_t   want;
    } dir_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [7:0]               s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [39:0]              m_tdata;
    logic                     cfg_we;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // predictor copy of registers and state
    logic [15:0]        inc_q;
    wave_t              wave_q;
    logic [9:0]         depth_q;
    logic [11:0]        interval_q;
    logic [15:0]        phase_acc;
    logic [11:0]        countdown;
    logic signed [15:0] held;
    int                 sine_q14 [0:ROM_LAST];

    lfo_out_t awaited_lfo [$];
    dir_row_t dir_rows [$];
    lfo_out_t due;
    int       mismatches;
    int       cycles;
    int       tx_idle_pct;
    int       rx_idle_pct;
    logic     hold_go;
    logic     rx_hold;

    lfo_vibrato_generator_core i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // quarter-wave entry k from a Q30 Taylor series, rounded to Q14
    function automatic int quarter_sine_point(int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      acc;
        logic [63:0] r;
        x    = (64'(k) * HALF_PI_Q30) >> ROM_BITS;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 7; n++)
        begin
            term = (term * x2) >> 30;
            term = term / (64'(2 * n) * 64'(2 * n + 1));
            if (n % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        r = (64'(acc) + 64'd32768) >> 16;
        if (r > 64'd16384)
        begin
            r = 64'd16384;
        end
        return int'(r);
    endfunction

    function automatic int shape_value(logic [15:0] p);
        logic [15:0] q;
        int          idx;
        int          d;
        q   = p ^ 16'h8000;
        idx = int'(q[13:6]);
        case (wave_q)
            WAVE_SINE:
            begin
                case (q[15:14])
                    2'd0:    return sine_q14[idx];
                    2'd1:    return sine_q14[ROM_LAST - idx];
                    2'd2:    return -sine_q14[idx];
                    default: return -sine_q14[ROM_LAST - idx];
                endcase
            end
            WAVE_TRIANGLE:
            begin
                d = (p >= 16'h8000) ? int'(p) - 32768 : 32768 - int'(p);
                return 16384 - d;
            end
            WAVE_SAW:
            begin
                return int'(p >> 1) - 16384;
            end
            default:
            begin
                return (p >= 16'h8000 || p == 16'h0000) ? 16384 : -16384;
            end
        endcase
    endfunction

    // 65536 + value*depth/1280, rounded half away from zero
    function automatic logic [16:0] vibrato_of(logic signed [15:0] v);
        longint prod;
        longint mag;
        longint adj;
        longint f;
        prod = longint'(v) * longint'(depth_q);
        mag  = (prod < 0) ? -prod : prod;
        adj  = (mag + 640) / 1280;
        if (prod < 0)
        begin
            adj = -adj;
        end
        f = 65536 + adj;
        if (f < 0)
        begin
            f = 0;
        end
        if (f > 131071)
        begin
            f = 131071;
        end
        return 17'(f);
    endfunction

    function automatic lfo_out_t advance_lfo(logic tick, logic clr);
        lfo_out_t o;
        o.updated = 1'b0;
        if (clr)
        begin
            phase_acc = 16'h8000;
            countdown = '0;
            held      = '0;
        end
        if (tick)
        begin
            if (countdown <= 12'd1)
            begin
                countdown = interval_q;
                phase_acc = phase_acc + inc_q;
                held      = 16'(shape_value(phase_acc));
                o.updated = 1'b1;
            end
            else
            begin
                countdown = countdown - 12'd1;
            end
        end
        o.value  = held;
        o.factor = vibrato_of(held);
        return o;
    endfunction

    function automatic void row_write(reg_index_t addr, logic [15:0] data);
        dir_row_t r;
        r          = '{addr: REG_PHASE_INC, default: '0};
        r.is_write = 1'b1;
        r.addr     = addr;
        r.data     = data;
        dir_rows.push_back(r);
    endfunction

    function automatic void row_item(logic tick, logic clr);
        dir_row_t r;
        r      = '{addr: REG_PHASE_INC, default: '0};
        r.tick = tick;
        r.clr  = clr;
        dir_rows.push_back(r);
    endfunction

    function automatic void row_known(logic tick, logic clr, int value, int factor, logic upd);
        dir_row_t r;
        r              = '{addr: REG_PHASE_INC, default: '0};
        r.tick         = tick;
        r.clr          = clr;
        r.known        = 1'b1;
        r.want.value   = 16'(value);
        r.want.factor  = 17'(factor);
        r.want.updated = upd;
        dir_rows.push_back(r);
    endfunction

    // one input transfer; the expectation is recorded at the accepting edge
    task automatic send_tick(logic tick, logic clr, logic known, lfo_out_t want);
        lfo_out_t p;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            @(negedge clk) s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, clr, tick};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        p = advance_lfo(tick, clr);
        awaited_lfo.push_back(known ? want : p);
    endtask

    // stop offering and wait for every outstanding result
    task automatic quiesce();
        @(negedge clk) s_tvalid <= 1'b0;
        while (awaited_lfo.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(reg_index_t idx, logic [15:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(negedge clk) cfg_we <= 1'b0;
        case (idx)
            REG_PHASE_INC: inc_q      = val;
            REG_WAVEFORM:  wave_q     = wave_t'(val[1:0]);
            REG_DEPTH:     depth_q    = val[9:0];
            default:       interval_q = val[11:0];
        endcase
    endtask

    // receiver: random stalls plus the long hold-off
    always @(negedge clk)
    begin
        m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    initial
    begin
        wait (hold_go);
        @(negedge clk) rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_lfo.size() == 0)
            begin
                $display("%0t: output transfer with nothing expected, actual %h",
                         $time, m_tdata);
                mismatches++;
            end
            else
            begin
                due = awaited_lfo.pop_front();
                if (m_tdata[15:0] !== due.value)
                begin
                    $display("%0t: lfo_value expected %0d actual %0d", $time,
                             due.value, $signed(m_tdata[15:0]));
                    mismatches++;
                end
                if (m_tdata[32:16] !== due.factor)
                begin
                    $display("%0t: vibrato_factor expected %0d actual %0d", $time,
                             due.factor, m_tdata[32:16]);
                    mismatches++;
                end
                if (m_tdata[33] !== due.updated)
                begin
                    $display("%0t: updated expected %0d actual %0d", $time,
                             due.updated, m_tdata[33]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_lfo_vibrato_generator_core failed");
            $finish;
        end
    end

    initial
    begin
        logic tick;
        logic clr;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = '0;
        cfg_data    = '0;
        mismatches  = 0;
        cycles      = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_go     = 1'b0;
        rx_hold     = 1'b0;
        inc_q       = '0;
        wave_q      = WAVE_SINE;
        depth_q     = '0;
        interval_q  = INTERVAL_RST;
        phase_acc   = 16'h8000;
        countdown   = '0;
        held        = '0;
        for (int k = 0; k <= ROM_LAST; k++)
        begin
            sine_q14[k] = quarter_sine_point(k);
        end

        // directed part: after reset, every shape, extreme increments and intervals
        row_known(1'b0, 1'b0, 0, 65536, 1'b0);
        row_known(1'b1, 1'b0, 0, 65536, 1'b1);
        row_known(1'b1, 1'b0, 0, 65536, 1'b0);
        row_write(REG_PHASE_INC, 16'h4000);
        row_write(REG_DEPTH, 16'd1023);
        row_write(REG_INTERVAL, 16'd1);
        row_item(1'b1, 1'b1);
        row_item(1'b1, 1'b0);
        row_item(1'b1, 1'b0);
        row_item(1'b0, 1'b0);
        row_write(REG_WAVEFORM, 16'(WAVE_TRIANGLE));
        row_item(1'b1, 1'b0);
        row_item(1'b1, 1'b0);
        row_item(1'b1, 1'b0);
        row_write(REG_WAVEFORM, 16'(WAVE_SAW));
        row_item(1'b1, 1'b0);
        row_write(REG_PHASE_INC, 16'hFFFF);
        row_item(1'b1, 1'b0);
        row_write(REG_WAVEFORM, 16'(WAVE_SQUARE));
        row_item(1'b1, 1'b1);
        row_item(1'b1, 1'b0);
        row_write(REG_PHASE_INC, 16'h8000);
        row_write(REG_DEPTH, 16'd0);
        row_write(REG_INTERVAL, 16'd4095);
        row_known(1'b0, 1'b1, 0, 65536, 1'b0);
        // restart leaves countdown at zero, so this tick lands on phase zero
        row_known(1'b1, 1'b0, 16384, 65536, 1'b1);
        row_known(1'b1, 1'b0, 16384, 65536, 1'b0);
        row_write(REG_INTERVAL, 16'd0);
        row_write(REG_DEPTH, 16'd1);
        row_item(1'b1, 1'b1);
        row_item(1'b1, 1'b0);
        row_item(1'b1, 1'b0);
        row_item(1'b0, 1'b1);

        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_write)
            begin
                quiesce();
                write_reg(dir_rows[i].addr, dir_rows[i].data);
            end
            else
            begin
                send_tick(dir_rows[i].tick, dir_rows[i].clr, dir_rows[i].known,
                          dir_rows[i].want);
            end
        end

        // random part: three stall profiles, several register settings each
        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 87 : 0;
            rx_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 18 : 0;
            for (int seg = 0; seg < 6; seg++)
            begin
                quiesce();
                case ($urandom_range(0, 4))
                    0:       write_reg(REG_PHASE_INC, 16'h0000);
                    1:       write_reg(REG_PHASE_INC, 16'hFFFF);
                    2:       write_reg(REG_PHASE_INC, 16'($urandom_range(1, 64)));
                    default: write_reg(REG_PHASE_INC, 16'($urandom));
                endcase
                write_reg(REG_WAVEFORM, 16'((seg + ph) % 4));
                case ($urandom_range(0, 3))
                    0:       write_reg(REG_DEPTH, 16'd0);
                    1:       write_reg(REG_DEPTH, 16'd1023);
                    default: write_reg(REG_DEPTH, 16'($urandom_range(0, 1023)));
                endcase
                case ($urandom_range(0, 5))
                    0:       write_reg(REG_INTERVAL, 16'd0);
                    1:       write_reg(REG_INTERVAL, 16'd4095);
                    2:       write_reg(REG_INTERVAL, 16'd1);
                    default: write_reg(REG_INTERVAL, 16'($urandom_range(2, 8)));
                endcase
                // long receiver hold-off while the sender keeps offering
                if (ph == 2 && seg == 0)
                begin
                    hold_go = 1'b1;
                end
                for (int n = 0; n < SEG_ITEMS; n++)
                begin
                    tick = ($urandom_range(0, 99) < 90);
                    clr  = ($urandom_range(0, 99) < 4);
                    send_tick(tick, clr, 1'b0, '0);
                end
            end
        end

        quiesce();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("tb_lfo_vibrato_generator_core passed");
        end
        else
        begin
            $display("tb_lfo_vibrato_generator_core failed");
        end
        $finish;
    end

endmodule
